@@ sv/ckd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckd_pkg
// Shared types and constants for the color key desaturation pipeline.
// ----------------------------------------------------------------------------
package ckd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_RED   = 3'd0,
    REG_KEY_GREEN = 3'd1,
    REG_KEY_BLUE  = 3'd2,
    REG_RADIUS    = 3'd3,
    REG_SOFT      = 3'd4,
    REG_BYPASS    = 3'd5
  } cfg_reg_t;

  // k = up to 3*255^2 = 195075, 18 bits; k << 16 is 34 bits.
  // Its root is a 17-bit value, so the square root runs 17 cells.
  localparam int unsigned KW      = 18;
  localparam int unsigned RadW    = 34;
  localparam int unsigned RootW   = 17;
  localparam int unsigned RemW    = 19;
  // Quotient (s << 8) / radius: dividend 25 bits, quotient below 2^25.
  localparam int unsigned DivNumW = 25;
  localparam int unsigned DivDenW = 9;
  localparam int unsigned DivRemW = 10;
  localparam int unsigned PW      = 17;
  localparam logic [PW-1:0] POne  = 17'h10000;

  // Per-pixel context carried alongside the arithmetic.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] gray;
    logic       pass;   // output the pixel unchanged
    logic       to_gray; // output gray
  } pix_t;

  // Square root cell state (restoring, one result bit per cell).
  typedef struct packed {
    logic [RadW-1:0]  rad;   // remaining radicand bits, shifted left
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

  // Divider cell state (restoring, one quotient bit per cell).
  typedef struct packed {
    logic [DivNumW-1:0] num;  // dividend bits, shifted left; quotient fills in
    logic [DivRemW-1:0] rem;
    logic [DivDenW-1:0] den;
  } dv_t;

endpackage

@@ sv/ckd_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckd_sqrt_cell
// One restoring square root step: bring down two radicand bits, try root bit.
// ----------------------------------------------------------------------------
module ckd_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  ckd_pkg::sq_t   sq_i,
  input  ckd_pkg::pix_t  pix_i,
  output logic           vld_o,
  output ckd_pkg::sq_t   sq_o,
  output ckd_pkg::pix_t  pix_o
);
  import ckd_pkg::*;

  logic          vld_r;
  sq_t           sq_r, sq_nxt;
  pix_t          pix_r;
  logic [RemW:0] trial;
  logic [RemW:0] cur;

  always_comb begin
    cur   = {sq_i.rem[RemW-2:0], sq_i.rad[RadW-1 -: 2]};
    trial = cur - {1'b0, sq_i.root, 2'b01};
    sq_nxt.rad = {sq_i.rad[RadW-3:0], 2'b00};
    if (!trial[RemW]) begin
      sq_nxt.rem  = trial[RemW-1:0];
      sq_nxt.root = {sq_i.root[RootW-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = cur[RemW-1:0];
      sq_nxt.root = {sq_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    sq_r  <= sq_nxt;
    pix_r <= pix_i;
  end

  assign vld_o = vld_r;
  assign sq_o  = sq_r;
  assign pix_o = pix_r;

endmodule

@@ sv/ckd_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckd_div_cell
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
module ckd_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  ckd_pkg::dv_t   dv_i,
  input  ckd_pkg::pix_t  pix_i,
  output logic           vld_o,
  output ckd_pkg::dv_t   dv_o,
  output ckd_pkg::pix_t  pix_o
);
  import ckd_pkg::*;

  logic             vld_r;
  dv_t              dv_r, dv_nxt;
  pix_t             pix_r;
  logic [DivRemW:0] cur;
  logic [DivRemW:0] diff;

  always_comb begin
    cur  = {dv_i.rem, dv_i.num[DivNumW-1]};
    diff = cur - {2'b00, dv_i.den};
    dv_nxt.den = dv_i.den;
    if (cur >= {2'b00, dv_i.den}) begin
      dv_nxt.rem = diff[DivRemW-1:0];
      dv_nxt.num = {dv_i.num[DivNumW-2:0], 1'b1};
    end else begin
      dv_nxt.rem = cur[DivRemW-1:0];
      dv_nxt.num = {dv_i.num[DivNumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    dv_r  <= dv_nxt;
    pix_r <= pix_i;
  end

  assign vld_o = vld_r;
  assign dv_o  = dv_r;
  assign pix_o = pix_r;

endmodule

@@ sv/color_key_desaturate_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_key_desaturate_top
// Selective color desaturation of one ARGB pixel per clock.
// ----------------------------------------------------------------------------
// A pixel is accepted in every cycle that start is high (busy is always low)
// and its result appears on out_* with out_valid high, in order, one pixel
// per clock. The pipeline is a chain of cells: 2 front stages (distance,
// squares), 17 square root cells that each produce one root bit, 25 divider
// cells that each produce one bit of p = sqrt(k)*65536/radius, and 3 blend
// stages (weights, products, sum/out).
// The result is shown for one cycle only; the receiver must take it then.
// Configuration writes are always accepted (cfg_ready is high) and should
// be made only while no pixel is in flight.
// ----------------------------------------------------------------------------
module color_key_desaturate_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [7:0]              in_red,
  input  logic [7:0]              in_green,
  input  logic [7:0]              in_blue,
  input  logic [7:0]              in_alpha,
  output logic                    out_valid,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic [7:0]              out_alpha,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [ckd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ckd_pkg::CfgDataW-1:0] cfg_data
);
  import ckd_pkg::*;

  localparam int unsigned NSq  = RootW;
  localparam int unsigned NDiv = DivNumW;

  // Configuration registers.
  logic [7:0] key_red_r, key_green_r, key_blue_r;
  logic [8:0] radius_r;
  logic       soft_r, bypass_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_red_r   <= 8'd0;
      key_green_r <= 8'd0;
      key_blue_r  <= 8'd0;
      radius_r    <= 9'd1;
      soft_r      <= 1'b0;
      bypass_r    <= 1'b0;
    end else if (cfg_valid) begin
      // Drop writes beyond the register list.
      unique case (cfg_index)
        REG_KEY_RED:   key_red_r   <= cfg_data[7:0];
        REG_KEY_GREEN: key_green_r <= cfg_data[7:0];
        REG_KEY_BLUE:  key_blue_r  <= cfg_data[7:0];
        REG_RADIUS:    radius_r    <= cfg_data;
        REG_SOFT:      soft_r      <= cfg_data[0];
        REG_BYPASS:    bypass_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: absolute differences and gray.
  logic        s1_vld_r;
  pix_t        s1_pix_r;
  logic [7:0]  dr_r, dg_r, db_r;
  logic [12:0] gsum;

  // Weighted sum reaches 8160, so it needs 13 bits before the shift.
  assign gsum = ({5'b0, in_red} * 13'd11 + {5'b0, in_green} * 13'd16 +
                 {5'b0, in_blue} * 13'd5) >> 5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    dr_r <= (in_red   > key_red_r)   ? in_red   - key_red_r   : key_red_r   - in_red;
    dg_r <= (in_green > key_green_r) ? in_green - key_green_r : key_green_r - in_green;
    db_r <= (in_blue  > key_blue_r)  ? in_blue  - key_blue_r  : key_blue_r  - in_blue;
    s1_pix_r.red     <= in_red;
    s1_pix_r.green   <= in_green;
    s1_pix_r.blue    <= in_blue;
    s1_pix_r.alpha   <= in_alpha;
    s1_pix_r.gray    <= gsum[7:0];
    s1_pix_r.pass    <= 1'b0;
    s1_pix_r.to_gray <= 1'b0;
  end

  // Stage 2: squared distance, decide pass / gray / blend.
  logic [KW-1:0]  k;
  logic [17:0]    r2;
  logic           s2_vld_r;
  pix_t           s2_pix_r;
  logic [KW-1:0]  k_r;

  assign k  = KW'({10'd0, dr_r} * {10'd0, dr_r}) + KW'({10'd0, dg_r} * {10'd0, dg_r})
            + KW'({10'd0, db_r} * {10'd0, db_r});
  assign r2 = {9'd0, radius_r} * {9'd0, radius_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    k_r      <= k;
    s2_pix_r <= '{red:     s1_pix_r.red,
                  green:   s1_pix_r.green,
                  blue:    s1_pix_r.blue,
                  alpha:   s1_pix_r.alpha,
                  gray:    s1_pix_r.gray,
                  pass:    bypass_r || (k <= r2 && (!soft_r || radius_r == 9'd0)),
                  to_gray: !bypass_r && (k > r2)};
  end

  // Square root chain.
  logic [NSq:0] sq_vld;
  sq_t          sq_bus [NSq+1];
  pix_t         sq_pix [NSq+1];

  assign sq_vld[0]  = s2_vld_r;
  assign sq_bus[0]  = '{rad: {k_r, 16'd0}, rem: '0, root: '0};
  assign sq_pix[0]  = s2_pix_r;

  for (genvar i = 0; i < NSq; i++) begin : g_sq
    ckd_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (sq_vld[i]),
      .sq_i  (sq_bus[i]),
      .pix_i (sq_pix[i]),
      .vld_o (sq_vld[i+1]),
      .sq_o  (sq_bus[i+1]),
      .pix_o (sq_pix[i+1])
    );
  end

  // Divider chain: (s << 8) / radius. The user must keep radius fixed while pixels fly; not enforced.
  logic [NDiv:0] dv_vld;
  dv_t           dv_bus [NDiv+1];
  pix_t          dv_pix [NDiv+1];
  logic [8:0]    den0;

  // Avoid a zero divisor; such pixels are already marked pass or gray.
  assign den0       = (radius_r == 9'd0) ? 9'd1 : radius_r;
  assign dv_vld[0]  = sq_vld[NSq];
  assign dv_bus[0]  = '{num: {sq_bus[NSq].root, 8'd0}, rem: '0, den: den0};
  assign dv_pix[0]  = sq_pix[NSq];

  for (genvar j = 0; j < NDiv; j++) begin : g_dv
    ckd_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (dv_vld[j]),
      .dv_i  (dv_bus[j]),
      .pix_i (dv_pix[j]),
      .vld_o (dv_vld[j+1]),
      .dv_o  (dv_bus[j+1]),
      .pix_o (dv_pix[j+1])
    );
  end

  // Blend stage A: clamp p, form weights.
  logic [PW-1:0] p_c;
  logic          ba_vld_r;
  pix_t          ba_pix_r;
  logic [PW-1:0] p_r, q_r;

  assign p_c = (dv_bus[NDiv].num > DivNumW'(POne)) ? POne : dv_bus[NDiv].num[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ba_vld_r <= 1'b0;
    end else begin
      ba_vld_r <= dv_vld[NDiv];
    end
    ba_pix_r <= dv_pix[NDiv];
    p_r      <= p_c;
    q_r      <= POne - p_c;
  end

  // Blend stage B: products, one multiplier per term.
  logic          bb_vld_r;
  pix_t          bb_pix_r;
  logic [24:0]   pr_r, pg_r, pb_r, pgr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_vld_r <= 1'b0;
    end else begin
      bb_vld_r <= ba_vld_r;
    end
    bb_pix_r <= ba_pix_r;
    pr_r     <= {8'd0, q_r} * {17'd0, ba_pix_r.red};
    pg_r     <= {8'd0, q_r} * {17'd0, ba_pix_r.green};
    pb_r     <= {8'd0, q_r} * {17'd0, ba_pix_r.blue};
    pgr_r    <= {8'd0, p_r} * {17'd0, ba_pix_r.gray};
  end

  // Blend stage C: sums and output select.
  logic [25:0] tr, tg, tb;
  logic        out_vld_r;
  logic [7:0]  ored_r, ogrn_r, oblu_r, oalp_r;

  assign tr = {1'b0, pr_r} + {1'b0, pgr_r};
  assign tg = {1'b0, pg_r} + {1'b0, pgr_r};
  assign tb = {1'b0, pb_r} + {1'b0, pgr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= bb_vld_r;
    end
    oalp_r <= bb_pix_r.alpha;
    priority if (bb_pix_r.pass) begin
      ored_r <= bb_pix_r.red;
      ogrn_r <= bb_pix_r.green;
      oblu_r <= bb_pix_r.blue;
    end else if (bb_pix_r.to_gray) begin
      ored_r <= bb_pix_r.gray;
      ogrn_r <= bb_pix_r.gray;
      oblu_r <= bb_pix_r.gray;
    end else begin
      ored_r <= tr[23:16];
      ogrn_r <= tg[23:16];
      oblu_r <= tb[23:16];
    end
  end

  assign out_valid = out_vld_r;
  assign out_red   = ored_r;
  assign out_green = ogrn_r;
  assign out_blue  = oblu_r;
  assign out_alpha = oalp_r;

  // Each accepted pixel yields a result a fixed latency later.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> ##(NSq + NDiv + 3) out_valid)
    else $error("pixel lost in pipeline");
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ba_vld_r, 2))
    else $error("result without pixel");
  a_gray_excl: assert property (@(posedge clk) disable iff (!rst_n)
    bb_vld_r |-> !(bb_pix_r.pass && bb_pix_r.to_gray))
    else $error("pass and gray both set");
  a_p_range: assert property (@(posedge clk) disable iff (!rst_n)
    ba_vld_r |-> (p_r <= POne))
    else $error("blend weight above one");

endmodule
